FILE: hdl/odq_pkg.sv
// ----------------------------------------------------------------------------
// odq_pkg - shared types, constants and tables of the ordered dither quantizer
// Holds the 8x8 threshold matrix, field widths, the per-depth reciprocal
// tables used for the constant divisions and the stage load struct.
// ----------------------------------------------------------------------------
package odq_pkg;

  // field widths
  localparam int CHAN_W    = 13;
  localparam int COL_W     = 12;
  localparam int WIDTH_W   = 13;
  localparam int DEPTH_W   = 4;
  localparam int MAX_WIDTH = 4096;
  localparam int PIX_W     = 8;

  // 8x8 threshold matrix, indexed [column mod 8][row mod 8]
  localparam logic [5:0] BAYER [8][8] = '{
    '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
    '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
    '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
    '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
    '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
    '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
    '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
    '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
  };

  // per-stage load enables shared by the lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } odq_ld_t;

  // quantizer level count 2^b - 1
  function automatic logic [7:0] level_count(input logic [DEPTH_W-1:0] b);
    logic [8:0] full;
    full = (9'd1 << b) - 9'd1;
    return full[7:0];
  endfunction

  // ceil(2^16 / b), exact for quotients of 11-bit values
  function automatic logic [16:0] recip_depth(input logic [DEPTH_W-1:0] b);
    case (b)
      4'd1:    return 17'd65536;
      4'd2:    return 17'd32768;
      4'd3:    return 17'd21846;
      4'd4:    return 17'd16384;
      4'd5:    return 17'd13108;
      4'd6:    return 17'd10923;
      4'd7:    return 17'd9363;
      default: return 17'd8192;
    endcase
  endfunction

  // integer part of 255 / (2^b - 1)
  function automatic logic [7:0] scale_int(input logic [DEPTH_W-1:0] b);
    case (b)
      4'd1:    return 8'd255;
      4'd2:    return 8'd85;
      4'd3:    return 8'd36;
      4'd4:    return 8'd17;
      4'd5:    return 8'd8;
      4'd6:    return 8'd4;
      4'd7:    return 8'd2;
      default: return 8'd1;
    endcase
  endfunction

  // remainder of 255 / (2^b - 1)
  function automatic logic [2:0] scale_rem(input logic [DEPTH_W-1:0] b);
    case (b)
      4'd3:    return 3'd3;
      4'd5:    return 3'd7;
      4'd6:    return 3'd3;
      4'd7:    return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  // ceil(2^15 / (2^b - 1)), only needed where the remainder is nonzero
  function automatic logic [12:0] recip_levels(input logic [DEPTH_W-1:0] b);
    case (b)
      4'd3:    return 13'd4682;
      4'd5:    return 13'd1058;
      4'd6:    return 13'd521;
      4'd7:    return 13'd259;
      default: return 13'd0;
    endcase
  endfunction

endpackage

FILE: hdl/odq_in_if.sv
// ----------------------------------------------------------------------------
// odq_in_if - pixel input channel
// Valid/ready handshake carrying one RGB pixel word and the frame start flag.
// ----------------------------------------------------------------------------
interface odq_in_if;
  logic        valid;
  logic        ready;
  logic        frame_start;
  logic [12:0] red_in;
  logic [12:0] green_in;
  logic [12:0] blue_in;

  modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

FILE: hdl/odq_out_if.sv
// ----------------------------------------------------------------------------
// odq_out_if - pixel output channel
// Valid/ready handshake carrying one quantized 8-bit RGB pixel word.
// ----------------------------------------------------------------------------
interface odq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: hdl/ordered_dither_quantizer_unit.sv
// ----------------------------------------------------------------------------
// ordered_dither_quantizer_unit - 8x8 ordered dither RGB quantizer
// Pixel words enter on pix_in (valid/ready), carrying a frame start flag and
// three unsigned Q1.12 channels. Each word is dithered with the 8x8 threshold
// matrix at its raster position, quantized to bit_depth bits per channel and
// rescaled to 8 bits, leaving on pix_out (valid/ready).
// Three channel lanes run side by side; a merge stage registers the result.
// An accepted word loads the first of four lane stages; three more lane
// stages and the output register follow. Throughput is one word per cycle
// unless pix_out stalls; stages 1-3 hold one multiply each, stage 4 two, and
// one more feeds the output register. Each stage moves forward whenever the
// stage ahead is empty or moving, so a stalled receiver only backs up the
// pipeline as far as it is full; pix_in.ready drops once every stage is full.
// The APB port holds image_width (0x0) and bit_depth (0x4); pready is always
// high. Write them only while no word is in flight.
// Reset clears the raster position, the stage valids and sets image_width to
// 640 and bit_depth to 1. A frame start word is column 0, row 0.
// ----------------------------------------------------------------------------
module ordered_dither_quantizer_unit (
  input  logic         clk,
  input  logic         rst,
  odq_in_if.sink       pix_in,
  odq_out_if.source    pix_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import odq_pkg::*;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_BIT_DEPTH   = 1'b1;

  logic [WIDTH_W-1:0] image_width;
  logic [DEPTH_W-1:0] bit_depth;
  logic [DEPTH_W-1:0] depth_eff;
  logic               cfg_wr;
  logic               accept;
  logic [5:0]         mval;
  logic [4:1]         stage_valid;
  logic [4:1]         adv;
  logic               take;
  odq_ld_t            ld;
  logic [PIX_W-1:0]   q_red;
  logic [PIX_W-1:0]   q_green;
  logic [PIX_W-1:0]   q_blue;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_W'(640);
      bit_depth   <= DEPTH_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH: image_width <= pwdata[WIDTH_W-1:0];
        REG_BIT_DEPTH:   bit_depth   <= pwdata[DEPTH_W-1:0];
        default:         image_width <= image_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH: prdata = {{(32-WIDTH_W){1'b0}}, image_width};
      REG_BIT_DEPTH:   prdata = {{(32-DEPTH_W){1'b0}}, bit_depth};
      default:         prdata = '0;
    endcase
  end

  // clamp depth to 1..8
  always_comb begin
    if (bit_depth == '0) begin
      depth_eff = DEPTH_W'(1);
    end else if (bit_depth > DEPTH_W'(8)) begin
      depth_eff = DEPTH_W'(8);
    end else begin
      depth_eff = bit_depth;
    end
  end

  // stage advance chain from the output register back to the input
  assign adv[4] = !stage_valid[4] || take;
  assign adv[3] = !stage_valid[3] || adv[4];
  assign adv[2] = !stage_valid[2] || adv[3];
  assign adv[1] = !stage_valid[1] || adv[2];

  assign pix_in.ready = adv[1];
  assign accept       = pix_in.valid && adv[1];

  assign ld.s1 = adv[1];
  assign ld.s2 = adv[2];
  assign ld.s3 = adv[3];
  assign ld.s4 = adv[4];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[1]) stage_valid[1] <= pix_in.valid;
      if (adv[2]) stage_valid[2] <= stage_valid[1];
      if (adv[3]) stage_valid[3] <= stage_valid[2];
      if (adv[4]) stage_valid[4] <= stage_valid[3];
    end
  end

  // raster position and threshold lookup
  odq_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (pix_in.frame_start),
    .image_width (image_width),
    .mval        (mval)
  );

  // channel lanes
  odq_lane u_lane_red (
    .clk   (clk),
    .ld    (ld),
    .depth (depth_eff),
    .chan  (pix_in.red_in),
    .mval  (mval),
    .q     (q_red)
  );

  odq_lane u_lane_green (
    .clk   (clk),
    .ld    (ld),
    .depth (depth_eff),
    .chan  (pix_in.green_in),
    .mval  (mval),
    .q     (q_green)
  );

  odq_lane u_lane_blue (
    .clk   (clk),
    .ld    (ld),
    .depth (depth_eff),
    .chan  (pix_in.blue_in),
    .mval  (mval),
    .q     (q_blue)
  );

  // merge and output register
  odq_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[4]),
    .q_red    (q_red),
    .q_green  (q_green),
    .q_blue   (q_blue),
    .take     (take),
    .pix_out  (pix_out)
  );

endmodule

FILE: hdl/odq_pos.sv
// ----------------------------------------------------------------------------
// odq_pos - raster position tracker
// Keeps the column and the row phase of the next pixel and looks up the
// threshold matrix entry for the pixel being accepted.
// ----------------------------------------------------------------------------
module odq_pos (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         frame_start,
  input  logic [odq_pkg::WIDTH_W-1:0]  image_width,
  output logic [5:0]                   mval
);
  import odq_pkg::*;

  logic [COL_W-1:0]   column_position;
  logic [2:0]         row_phase;
  logic [COL_W-1:0]   col_cur;
  logic [2:0]         row_cur;
  logic [WIDTH_W-1:0] width_eff;
  logic [WIDTH_W-1:0] col_inc;

  // clamp the programmed width to 1..MAX_WIDTH
  always_comb begin
    if (image_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
  end

  // frame start restarts at the top left corner
  assign col_cur = frame_start ? '0 : column_position;
  assign row_cur = frame_start ? '0 : row_phase;
  assign col_inc = {1'b0, col_cur} + WIDTH_W'(1);
  assign mval    = BAYER[col_cur[2:0]][row_cur];

  // advance position per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_phase       <= '0;
    end else if (accept) begin
      if (col_inc >= width_eff) begin
        column_position <= '0;
        row_phase       <= row_cur + 3'd1;
      end else begin
        column_position <= col_inc[COL_W-1:0];
        row_phase       <= row_cur;
      end
    end
  end

endmodule

FILE: hdl/odq_lane.sv
// ----------------------------------------------------------------------------
// odq_lane - one color channel quantizer lane
// Adds the scaled dither offset, clamps, rounds to 2^b-1 levels and rescales
// the level to 0..255 over four register stages; the last add feeds the
// output register in the merge stage.
// ----------------------------------------------------------------------------
module odq_lane (
  input  logic                         clk,
  input  odq_pkg::odq_ld_t             ld,
  input  logic [odq_pkg::DEPTH_W-1:0]  depth,
  input  logic [odq_pkg::CHAN_W-1:0]   chan,
  input  logic [5:0]                   mval,
  output logic [odq_pkg::PIX_W-1:0]    q
);
  import odq_pkg::*;

  logic [16:0] chan_b;
  logic [18:0] offset;
  logic [18:0] s_raw;
  logic [15:0] s_top;
  logic [15:0] s_clamp;
  logic [15:0] s_q;
  logic [23:0] sl;
  logic [23:0] num;
  logic [10:0] x_q;
  logic [27:0] xm;
  logic [7:0]  lvl_q;
  logic [15:0] base_full;
  logic [10:0] z_full;
  logic [7:0]  base_q;
  logic [7:0]  z_q;
  logic [20:0] zm;

  // stage 1: channel * b + (M - 32) * 64, clamped to [0, 4096 * b]
  assign chan_b = 17'(chan) * 17'(depth);
  assign offset = ({13'd0, mval} - 19'd32) << 6;
  assign s_raw  = {2'b00, chan_b} + offset;
  assign s_top  = {depth, 12'd0};

  always_comb begin
    if (s_raw[18]) begin
      s_clamp = '0;
    end else if (s_raw[17:0] > {2'b00, s_top}) begin
      s_clamp = s_top;
    end else begin
      s_clamp = s_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      s_q <= s_clamp;
    end
  end

  // stage 2: (2 * s * L + 4096 * b) / 8192
  assign sl  = 24'(s_q) * 24'(level_count(depth));
  assign num = (sl << 1) + 24'({depth, 12'd0});

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      x_q <= num[23:13];
    end
  end

  // stage 3: divide by b through reciprocal multiply
  assign xm = 28'(x_q) * 28'(recip_depth(depth));

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      lvl_q <= xm[23:16];
    end
  end

  // stage 4: split level * 255 / L into integer part and remainder term
  assign base_full = 16'(lvl_q) * 16'(scale_int(depth));
  assign z_full    = 11'(lvl_q) * 11'(scale_rem(depth));

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      base_q <= base_full[7:0];
      z_q    <= z_full[7:0];
    end
  end

  // remainder term divided by L, then summed
  assign zm = 21'(z_q) * 21'(recip_levels(depth));
  assign q  = base_q + {2'b00, zm[20:15]};

endmodule

FILE: hdl/odq_merge.sv
// ----------------------------------------------------------------------------
// odq_merge - lane merge and output register
// Packs the three lane results into one output word and holds it until the
// receiver takes it.
// ----------------------------------------------------------------------------
module odq_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [odq_pkg::PIX_W-1:0]  q_red,
  input  logic [odq_pkg::PIX_W-1:0]  q_green,
  input  logic [odq_pkg::PIX_W-1:0]  q_blue,
  output logic                       take,
  odq_out_if.source                  pix_out
);
  import odq_pkg::*;

  // register is free when empty or being drained
  assign take = !pix_out.valid || pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (take) begin
      pix_out.valid <= in_valid;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (take) begin
      pix_out.red_out   <= q_red;
      pix_out.green_out <= q_green;
      pix_out.blue_out  <= q_blue;
    end
  end

endmodule
